@@ hdl/ldv_pkg.sv @@
// shared types and constants for the ldt descriptor validator
package ldv_pkg;

  localparam int unsigned TABLE_ENTRIES = 8192;
  localparam int unsigned IDX_W         = 13;

  localparam logic [31:0] USER_CEILING   = 32'h7ffe_ffff;
  localparam logic [31:0] SEL_HIGH_MASK  = 32'hffff_0000;
  localparam logic [31:0] GRAN_BIT       = 32'h0080_0000;
  localparam logic [31:0] PRESENT_BIT    = 32'h0000_8000;
  localparam logic [31:0] KIND_MASK      = 32'h0000_7f00;
  localparam logic [31:0] APP_BIT        = 32'h0000_1000;
  localparam logic [31:0] CONF_CODE_MASK = 32'h0000_1c00;
  localparam logic [31:0] DPL_MASK       = 32'h0000_6000;
  localparam logic [31:0] PAGE_FILL      = 32'h0000_0fff;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [31:0] selector;
    logic [31:0] entry_low;
    logic [31:0] entry_high;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             write_entry;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      seg_base;
    logic [31:0]      seg_limit;
  } rsp_t;

endpackage

@@ hdl/ldv_if.sv @@
// valid/ready channel interfaces for requests, results and configuration
interface ldv_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] selector;
  logic [31:0] entry_low;
  logic [31:0] entry_high;

  modport source (output valid, output selector, output entry_low, output entry_high,
                  input ready);
  modport sink   (input valid, input selector, input entry_low, input entry_high,
                  output ready);
endinterface

interface ldv_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        write_entry;
  logic [12:0] entry_index;
  logic [31:0] seg_base;
  logic [31:0] seg_limit;

  modport source (output valid, output status, output write_entry, output entry_index,
                  output seg_base, output seg_limit, input ready);
  modport sink   (input valid, input status, input write_entry, input entry_index,
                  input seg_base, input seg_limit, output ready);
endinterface

interface ldv_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ldv_check.sv @@
// descriptor decode and validity checks for one request
module ldv_check (
  input  ldv_pkg::req_t req,
  input  logic          table_ready,
  output ldv_pkg::rsp_t rsp
);
  import ldv_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [31:0]      base;
  logic [31:0]      raw_limit;
  logic [31:0]      limit;
  logic [32:0]      seg_end;
  logic             range_bad;
  logic             kind_bad;
  logic             desc_ok;
  logic [31:0]      hi;

  assign hi        = req.entry_high;
  assign idx       = req.selector[IDX_W+2:3];
  assign base      = {hi[31:24], hi[7:0], req.entry_low[31:16]};
  assign raw_limit = {12'h000, hi[19:16], req.entry_low[15:0]};
  assign limit     = ((hi & GRAN_BIT) != '0) ? ((raw_limit << 12) | PAGE_FILL) : raw_limit;
  assign seg_end   = {1'b0, base} + {1'b0, limit};

  // wrap shows as a carry out of the 32-bit sum
  assign range_bad = (base > USER_CEILING) || seg_end[32] || (seg_end[31:0] > USER_CEILING);

  assign kind_bad  = ((hi & APP_BIT) == '0) ||
                     ((hi & CONF_CODE_MASK) == CONF_CODE_MASK) ||
                     ((hi & DPL_MASK) != DPL_MASK);

  assign desc_ok   = !(((hi & PRESENT_BIT) != '0) && range_bad) &&
                     !(((hi & KIND_MASK) != '0) && kind_bad);

  always_comb begin
    rsp.entry_index = idx;
    rsp.seg_base    = base;
    rsp.seg_limit   = limit;
    rsp.status      = STATUS_OK;
    rsp.write_entry = 1'b0;
    priority if ((req.selector & SEL_HIGH_MASK) != '0) begin
      rsp.status = STATUS_INVALID;
    end else if (idx == '0) begin
      rsp.status = STATUS_OK;
    end else if (({1'b0, idx} >= (IDX_W+1)'(TABLE_ENTRIES)) || !table_ready) begin
      rsp.status = STATUS_INVALID;
    end else if (!desc_ok) begin
      rsp.status = STATUS_INVALID;
    end else begin
      rsp.write_entry = 1'b1;
    end
  end

endmodule

@@ hdl/ldt_descriptor_validate.sv @@
// top level: ldt descriptor validator with input and result registers
// an accepted item is held in the input register, then moves into the result register,
//   which offers it, once that register is empty or its result is being taken
// throughput: one item per cycle; the input register and result register form a
//   two-stage pipeline that advances whenever the result register is empty or taken
// reset: synchronous active-low rst_n empties both stages and clears table_ready
module ldt_descriptor_validate (
  input  logic     clk,
  input  logic     rst_n,
  ldv_req_if.sink  in_ch,
  ldv_rsp_if.source out_ch,
  ldv_cfg_if.sink  cfg_ch
);
  import ldv_pkg::*;

  // configuration register
  logic tbl_ready_r;

  // stage 1: registered request
  logic s1_valid_r;
  req_t s1_req_r;

  // stage 2: registered result
  logic out_valid_r;
  rsp_t out_rsp_r;
  rsp_t rsp_nxt;

  logic adv;        // stage 1 moves into the result register
  logic in_take;    // item accepted on the input channel

  // result register frees up when empty or being taken this cycle
  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_take = in_ch.valid && in_ch.ready;

  // configuration is always accepted
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_ready_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      tbl_ready_r <= cfg_ch.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= '{selector: in_ch.selector, entry_low: in_ch.entry_low,
                    entry_high: in_ch.entry_high};
    end
  end

  // decode and checks between the two registers
  ldv_check u_check (
    .req         (s1_req_r),
    .table_ready (tbl_ready_r),
    .rsp         (rsp_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_rsp_r.status;
  assign out_ch.write_entry = out_rsp_r.write_entry;
  assign out_ch.entry_index = out_rsp_r.entry_index;
  assign out_ch.seg_base    = out_rsp_r.seg_base;
  assign out_ch.seg_limit   = out_rsp_r.seg_limit;

  // a write request always carries success status
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.write_entry && (out_rsp_r.status == STATUS_INVALID)))
    else $error("write_entry set with invalid status");

  // no table means nothing gets written
  a_no_table_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !tbl_ready_r) |=> !out_rsp_r.write_entry)
    else $error("write_entry set without a table");

  // full pipeline with a stalled result must not take a new item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("item accepted into a full pipeline");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule

@@ bench/tb_ldt_descriptor_validate.sv @@
// self-checking bench for the ldt descriptor validator: directed and random items
module tb_ldt_descriptor_validate;
  import ldv_pkg::*;

  // generous ceiling for a correct run with the slow idling phases
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // long result hold-off in the no-idle phase, so the pipeline fills and back-pressures
  localparam int unsigned HOLD_CYCLES   = 250;
  // pipeline is two deep; an extra wait after draining before touching the register
  localparam int unsigned SETTLE_CYCLES = 6;

  // who idles: receiver slow, sender slow, or nobody
  typedef enum logic [1:0] {PLAN_RX_SLOW, PLAN_TX_SLOW, PLAN_NO_IDLE} idle_plan_t;

  logic clk = 1'b0;
  logic rst_n;

  ldv_req_if in_ch();
  ldv_rsp_if out_ch();
  ldv_cfg_if cfg_ch();

  ldt_descriptor_validate dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // items waiting to be offered, and verdicts waiting to come out
  req_t       pending[$];
  rsp_t       verdicts_due[$];
  // our copy of table_ready, follows every accepted register write
  logic       table_on = 1'b0;
  idle_plan_t plan = PLAN_RX_SLOW;

  int unsigned n_accepted   = 0;
  int unsigned n_written    = 0;
  int unsigned n_rejected   = 0;
  int unsigned n_zero_index = 0;
  int unsigned n_fail       = 0;
  int unsigned n_cycles     = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  initial forever #5 clk = ~clk;

  // expected verdict for one request under the given table_ready
  function automatic rsp_t judge_descriptor(req_t r, logic tbl);
    rsp_t        v;
    logic [31:0] hi;
    logic [31:0] seg_end;
    logic        shape_ok;
    hi            = r.entry_high;
    v.status      = STATUS_OK;
    v.write_entry = 1'b0;
    v.entry_index = r.selector[15:3];
    // base is scattered over both words, limit is 20 bits
    v.seg_base    = {hi[31:24], hi[7:0], r.entry_low[31:16]};
    v.seg_limit   = {12'h000, hi[19:16], r.entry_low[15:0]};
    if ((hi & GRAN_BIT) != 0) begin
      v.seg_limit = (v.seg_limit << 12) | PAGE_FILL;
    end
    seg_end  = v.seg_base + v.seg_limit;
    shape_ok = 1'b1;
    // present: no wrap, whole segment at or under the user ceiling
    if ((hi & PRESENT_BIT) != 0 && (v.seg_base > USER_CEILING || seg_end < v.seg_base ||
                                    seg_end > USER_CEILING)) begin
      shape_ok = 1'b0;
    end
    // any kind bits: must be application, dpl 3, not conforming code
    if ((hi & KIND_MASK) != 0 && ((hi & APP_BIT) == 0 ||
                                  (hi & CONF_CODE_MASK) == CONF_CODE_MASK ||
                                  (hi & DPL_MASK) != DPL_MASK)) begin
      shape_ok = 1'b0;
    end
    if ((r.selector & SEL_HIGH_MASK) != 0) begin
      v.status = STATUS_INVALID;
    end else if (v.entry_index == 0) begin
      // index zero passes with no write and no further checks
      v.status = STATUS_OK;
    end else if (32'(v.entry_index) >= TABLE_ENTRIES || !tbl || !shape_ok) begin
      v.status = STATUS_INVALID;
    end else begin
      v.write_entry = 1'b1;
    end
    return v;
  endfunction

  function automatic req_t request_of(logic [31:0] sel, logic [31:0] lo, logic [31:0] hi);
    req_t r;
    r.selector   = sel;
    r.entry_low  = lo;
    r.entry_high = hi;
    return r;
  endfunction

  // mostly well-formed descriptors with random content, the rest raw noise
  function automatic req_t random_request();
    req_t        r;
    logic [31:0] base;
    logic [31:0] hi;
    logic [19:0] lim;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.selector = $urandom();                             // high bits usually set
    end else if (pick < 14) begin
      r.selector = {29'h0, 3'($urandom_range(0, 7))};      // index zero
    end else begin
      r.selector = {16'h0, 16'($urandom())};
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.entry_low  = $urandom();
      r.entry_high = $urandom();
    end else begin
      case ($urandom_range(0, 3))
        0, 1:    base = $urandom_range(0, 32'h00ff_ffff);
        2:       base = USER_CEILING - $urandom_range(0, 32'h0002_0000);
        default: base = $urandom();
      endcase
      lim = 20'($urandom());
      if ($urandom_range(0, 2) == 0) begin
        lim = 20'($urandom_range(0, 255));
      end
      hi        = {base[31:24], 8'h00, 8'h00, base[23:16]};
      hi[19:16] = lim[19:16];
      hi[22:20] = 3'($urandom());
      hi[23]    = 1'($urandom_range(0, 1));
      hi[15]    = ($urandom_range(0, 9) != 0);
      if (pick < 35) begin
        hi[14:8] = 7'h00;                                  // kind checks skipped
      end else if (pick < 45) begin
        hi[14:8] = 7'($urandom());
      end else begin
        hi[14:13] = 2'b11;                                 // application, dpl 3
        hi[12]    = 1'b1;
        hi[11:8]  = 4'($urandom());
      end
      r.entry_low  = {base[15:0], lim[15:0]};
      r.entry_high = hi;
    end
    return r;
  endfunction

  function automatic bit sender_rests();
    case (plan)
      PLAN_RX_SLOW: return $urandom_range(0, 99) < 29;
      PLAN_TX_SLOW: return $urandom_range(0, 99) < 79;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (plan)
      PLAN_RX_SLOW: return $urandom_range(0, 99) < 79;
      PLAN_TX_SLOW: return $urandom_range(0, 99) < 29;
      default:      return 1'b0;
    endcase
  endfunction

  // request driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk) begin : drive_requests
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdicts_due.push_back(judge_descriptor(
          {in_ch.selector, in_ch.entry_low, in_ch.entry_high}, table_on));
        n_accepted++;
      end
      // channel free: either nothing offered or the offer was just taken
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() != 0 && !sender_rests()) begin
          nxt               = pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.selector   <= nxt.selector;
          in_ch.entry_low  <= nxt.entry_low;
          in_ch.entry_high <= nxt.entry_high;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random stalls, plus one long hold-off in the no-idle phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (plan == PLAN_NO_IDLE && !hold_done && out_ch.valid) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= !receiver_rests();
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endtask

  // result monitor: every taken item against the oldest verdict
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        n_fail++;
        $error("result item arrived with no verdict pending");
      end else begin
        want = verdicts_due.pop_front();
        check_field("status",      32'(want.status),      32'(out_ch.status));
        check_field("write_entry", 32'(want.write_entry), 32'(out_ch.write_entry));
        check_field("entry_index", 32'(want.entry_index), 32'(out_ch.entry_index));
        check_field("seg_base",    want.seg_base,         out_ch.seg_base);
        check_field("seg_limit",   want.seg_limit,        out_ch.seg_limit);
        if (want.write_entry) n_written++;
        else if (want.status == STATUS_INVALID) n_rejected++;
        else n_zero_index++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // wait until the block is empty: nothing queued, offered or in flight
  task automatic settle();
    while (pending.size() != 0 || in_ch.valid || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write over the config channel, only while idle
  task automatic set_table_ready(input logic v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    table_on = v;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.selector   = '0;
    in_ch.entry_low  = '0;
    in_ch.entry_high = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // table not set up after reset: only index zero gets through
    pending.push_back(request_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    pending.push_back(request_of(32'h0000_0008, 32'h0000_0000, 32'h0000_0000));
    pending.push_back(request_of(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    pending.push_back(request_of(32'h0000_fff8, 32'h0000_ffff, 32'h0000_f200));
    pending.push_back(request_of(32'h0000_0005, 32'hdead_beef, 32'h1234_5678));
    settle();

    set_table_ready(1'b1);
    // index zero, and index zero with garbage descriptor and low selector bits
    pending.push_back(request_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    pending.push_back(request_of(32'h0000_0007, 32'hffff_ffff, 32'hffff_ffff));
    // blank descriptor, not present, no kind bits: stored
    pending.push_back(request_of(32'h0000_0008, 32'h0000_0000, 32'h0000_0000));
    // top index with all-ones words
    pending.push_back(request_of(32'h0000_ffff, 32'hffff_ffff, 32'hffff_ffff));
    // high selector bits set
    pending.push_back(request_of(32'h0001_0008, 32'h0000_ffff, 32'h0000_f200));
    pending.push_back(request_of(32'h8000_0000, 32'h0000_0000, 32'h0000_0000));
    // present data segment, dpl 3
    pending.push_back(request_of(32'h0000_0010, 32'h0000_ffff, 32'h0000_f200));
    // base exactly at the ceiling, then the same base with a limit one byte past it
    pending.push_back(request_of(32'h0000_0018, 32'hffff_0000, 32'h7f00_f2fe));
    pending.push_back(request_of(32'h0000_0020, 32'hffff_0001, 32'h7f00_f2fe));
    // granular 4 GiB limit from base 1 wraps around
    pending.push_back(request_of(32'h0000_0028, 32'h0001_ffff, 32'h008f_f200));
    // base over the ceiling but not present: range checks skipped
    pending.push_back(request_of(32'h0000_0030, 32'hffff_0000, 32'hff00_72ff));
    // system descriptor, conforming code, readable code
    pending.push_back(request_of(32'h0000_0038, 32'h0000_1000, 32'h0000_e200));
    pending.push_back(request_of(32'h0000_0040, 32'h0000_1000, 32'h0000_fe00));
    pending.push_back(request_of(32'h0000_0048, 32'h0000_1000, 32'h0000_fa00));
    // privilege 0 and 2
    pending.push_back(request_of(32'h0000_0050, 32'h0000_1000, 32'h0000_9200));
    pending.push_back(request_of(32'h0000_0058, 32'h0000_1000, 32'h0000_d200));
    // granular zero limit, lone type bit with no application flag
    pending.push_back(request_of(32'h0000_0060, 32'h0000_0000, 32'h00c0_f200));
    pending.push_back(request_of(32'h0000_0068, 32'h0000_0000, 32'h0000_0100));
    // receiver slow phase
    repeat (350) pending.push_back(random_request());
    settle();

    // table withdrawn, sender slow
    set_table_ready(1'b0);
    plan <= PLAN_TX_SLOW;
    repeat (100) pending.push_back(random_request());
    settle();

    set_table_ready(1'b1);
    repeat (330) pending.push_back(random_request());
    settle();

    // full speed, with the long result hold-off
    plan <= PLAN_NO_IDLE;
    repeat (350) pending.push_back(random_request());
    settle();

    $display("%0d items checked over table off and on; %0d stored, %0d refused, %0d index zero",
             n_accepted, n_written, n_rejected, n_zero_index);
    $display("idling swept receiver-slow, sender-slow and none, long result hold-off %s",
             hold_done ? "done" : "missed");
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
